// File: hw/rtl/ttl_pkg.sv
`default_nettype none

package ttl_pkg;

  localparam int REF_W        = 14;
  localparam int MV_W         = 14;
  localparam int VOLT_W       = 12;
  localparam int SEG_W        = 5;
  localparam int TABLE_POINTS = 29;
  localparam int LAST_SEG     = TABLE_POINTS - 1;
  localparam int NEG_SEG_LAST = 6;
  localparam int DEN_W        = 8;
  localparam int NUM_W        = 11;
  localparam int Q_W          = 3;
  localparam int TEMP_W       = 9;
  localparam int TEMP_STEP    = 5;
  localparam int OUT_TDATA_W  = ((TEMP_W + 7) / 8) * 8;
  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int PADDR_W      = 2;
  localparam int PDATA_W      = 32;

  localparam logic [PADDR_W-1:0] REG_REF_MV = PADDR_W'(0);
  localparam logic [REF_W-1:0]   REF_RESET  = REF_W'(4096);

  localparam logic signed [TEMP_W-1:0] TEMP_LOW_MARK  = 9'sd150;
  localparam logic signed [TEMP_W-1:0] TEMP_HIGH_MARK = -9'sd35;
  localparam logic signed [TEMP_W-1:0] TEMP_FIRST     = -9'sd30;

  typedef enum logic [1:0] {
    CLS_SEG  = 2'd0,
    CLS_LOW  = 2'd1,
    CLS_HIGH = 2'd2
  } cls_t;

  typedef struct packed {
    cls_t              cls;
    logic [MV_W-1:0]   mv;
    logic [SEG_W-1:0]  seg;
  } item_t;

  function automatic logic [VOLT_W-1:0] volt_point(input logic [SEG_W-1:0] idx);
    logic [VOLT_W-1:0] v;
    case (idx)
      5'd0:    v = 12'd3980;
      5'd1:    v = 12'd3940;
      5'd2:    v = 12'd3890;
      5'd3:    v = 12'd3826;
      5'd4:    v = 12'd3748;
      5'd5:    v = 12'd3653;
      5'd6:    v = 12'd3541;
      5'd7:    v = 12'd3409;
      5'd8:    v = 12'd3259;
      5'd9:    v = 12'd3091;
      5'd10:   v = 12'd2908;
      5'd11:   v = 12'd2712;
      5'd12:   v = 12'd2508;
      5'd13:   v = 12'd2300;
      5'd14:   v = 12'd2093;
      5'd15:   v = 12'd1890;
      5'd16:   v = 12'd1696;
      5'd17:   v = 12'd1513;
      5'd18:   v = 12'd1343;
      5'd19:   v = 12'd1188;
      5'd20:   v = 12'd1047;
      5'd21:   v = 12'd921;
      5'd22:   v = 12'd809;
      5'd23:   v = 12'd710;
      5'd24:   v = 12'd623;
      5'd25:   v = 12'd546;
      5'd26:   v = 12'd480;
      5'd27:   v = 12'd421;
      5'd28:   v = 12'd371;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic signed [TEMP_W-1:0] seg_base(input logic [SEG_W-1:0] seg);
    logic [TEMP_W-1:0] off;
    off = TEMP_W'(seg - SEG_W'(1)) * TEMP_W'(TEMP_STEP);
    return TEMP_FIRST + $signed(off);
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/ttl_front.sv
`default_nettype none

module ttl_front
  import ttl_pkg::*;
#(
  parameter int SAMPLE_BITS = 10
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [SAMPLE_BITS-1:0] raw,
  input  wire logic [REF_W-1:0]       ref_mv,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output item_t                       out_item
);

  localparam int PROD_W = SAMPLE_BITS + REF_W;

  logic              a_valid;
  logic [PROD_W-1:0] prod;
  logic              b_valid;
  item_t             b_item;
  logic              en_a;
  logic              en_b;

  logic [PROD_W-1:0]       rounded;
  logic [MV_W-1:0]         mv_c;
  logic [TABLE_POINTS-1:0] lt;
  logic [SEG_W-1:0]        seg_or;
  logic                    seg_hit;
  item_t                   item_c;

  assign en_b     = !b_valid || out_ready;
  assign en_a     = !a_valid || en_b;
  assign in_ready = en_a;

  always_comb begin
    rounded = prod + (PROD_W'(1) << (SAMPLE_BITS - 1));
    mv_c    = rounded[PROD_W-1:SAMPLE_BITS];
    for (int j = 0; j < TABLE_POINTS; j++) begin
      lt[j] = {{(MV_W - VOLT_W){1'b0}}, volt_point(SEG_W'(j))} < mv_c;
    end
    seg_or = '0;
    for (int j = 1; j < TABLE_POINTS; j++) begin
      if (lt[j] && !lt[j-1]) begin
        seg_or = seg_or | SEG_W'(j);
      end
    end
    seg_hit = |lt[TABLE_POINTS-1:1];
    item_c.mv  = mv_c;
    item_c.seg = seg_hit ? seg_or : SEG_W'(LAST_SEG);
    if (mv_c < {{(MV_W - VOLT_W){1'b0}}, volt_point(SEG_W'(LAST_SEG))}) begin
      item_c.cls = CLS_LOW;
    end else if (lt[0]) begin
      item_c.cls = CLS_HIGH;
    end else begin
      item_c.cls = CLS_SEG;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else begin
      if (en_a) begin
        a_valid <= in_valid;
      end
      if (en_b) begin
        b_valid <= a_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en_a && in_valid) begin
      prod <= PROD_W'(raw) * PROD_W'(ref_mv);
    end
    if (en_b && a_valid) begin
      b_item <= item_c;
    end
  end

  assign out_valid = b_valid;
  assign out_item  = b_item;

endmodule

`default_nettype wire

// File: hw/rtl/ttl_queue.sv
`default_nettype none

module ttl_queue
  import ttl_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire item_t in_item,
  output logic       out_valid,
  input  wire logic  out_ready,
  output item_t      out_item
);

  item_t             slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              push;
  logic              pop;

  assign in_ready  = count != (QPTR_W + 1)'(QUEUE_DEPTH);
  assign out_valid = count != '0;
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_item  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + (QPTR_W + 1)'(1);
      end else if (pop && !push) begin
        count <= count - (QPTR_W + 1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_item;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/ttl_back.sv
`default_nettype none

module ttl_back
  import ttl_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire item_t               in_item,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic signed [TEMP_W-1:0] temperature
);

  logic                     c_valid;
  cls_t                     c_cls;
  logic [NUM_W-1:0]         c_num;
  logic [DEN_W-1:0]         c_den;
  logic signed [TEMP_W-1:0] c_base;
  logic                     d_valid;
  logic signed [TEMP_W-1:0] d_temp;
  logic                     en_c;
  logic                     en_d;

  logic [VOLT_W-1:0]        hi;
  logic [VOLT_W-1:0]        lo;
  logic [DEN_W-1:0]         den_c;
  logic [MV_W-1:0]          diff_full;
  logic [NUM_W-1:0]         num_c;
  logic                     neg_c;

  logic [NUM_W-1:0]         rem;
  logic [NUM_W-1:0]         dsh;
  logic [Q_W-1:0]           q;
  logic signed [TEMP_W-1:0] temp_c;

  assign en_d     = !d_valid || out_ready;
  assign en_c     = !c_valid || en_d;
  assign in_ready = en_c;

  always_comb begin
    hi        = volt_point(in_item.seg - SEG_W'(1));
    lo        = volt_point(in_item.seg);
    den_c     = DEN_W'(hi - lo);
    diff_full = {{(MV_W - VOLT_W){1'b0}}, hi} - in_item.mv;
    neg_c     = in_item.seg <= SEG_W'(NEG_SEG_LAST);
    num_c     = NUM_W'(diff_full[DEN_W-1:0]) * NUM_W'(TEMP_STEP);
    if (neg_c) begin
      num_c = num_c + NUM_W'(den_c) - NUM_W'(1);
    end
  end

  always_comb begin
    rem = c_num;
    q   = '0;
    for (int i = Q_W - 1; i >= 0; i--) begin
      dsh = NUM_W'(c_den) << i;
      if (rem >= dsh) begin
        rem  = rem - dsh;
        q[i] = 1'b1;
      end
    end
    case (c_cls)
      CLS_LOW:  temp_c = TEMP_LOW_MARK;
      CLS_HIGH: temp_c = TEMP_HIGH_MARK;
      default:  temp_c = c_base + $signed(TEMP_W'(q));
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
      d_valid <= 1'b0;
    end else begin
      if (en_c) begin
        c_valid <= in_valid;
      end
      if (en_d) begin
        d_valid <= c_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en_c && in_valid) begin
      c_cls  <= in_item.cls;
      c_num  <= num_c;
      c_den  <= den_c;
      c_base <= seg_base(in_item.seg);
    end
    if (en_d && c_valid) begin
      d_temp <= temp_c;
    end
  end

  assign out_valid   = d_valid;
  assign temperature = d_temp;

endmodule

`default_nettype wire

// File: hw/rtl/thermistor_table_linearizer.sv
// Channel   Direction  Handshake                  Content
// s_*       in         s_tvalid / s_tready        raw converter sample
// m_*       out        m_tvalid / m_tready        temperature in degrees Celsius
// APB       in/out     psel, penable, pready      reference voltage register
//
// One sample is taken every cycle when the output is not stalled; a result passes
// through two front stages (scale, classify), the queue and two back stages
// (interpolation setup, three-bit divide).
// Reset clears all pipeline valids and the queue and sets the reference to 4096 mV.
// A stall on the output fills the two back stages, the four-entry queue and the two
// front stages before the input stops taking samples.
`default_nettype none

module thermistor_table_linearizer
  import ttl_pkg::*;
#(
  parameter int SAMPLE_BITS = 10
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     s_tvalid,
  output logic                          s_tready,
  // raw_sample
  input  wire logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] s_tdata,
  output logic                          m_tvalid,
  input  wire logic                     m_tready,
  // temperature
  output logic [OUT_TDATA_W-1:0]        m_tdata,
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic [PADDR_W-1:0]       paddr,
  input  wire logic [PDATA_W-1:0]       pwdata,
  output logic [PDATA_W-1:0]            prdata,
  output logic                          pready
);

  logic [REF_W-1:0]         ref_mv;
  logic                     f_valid;
  logic                     f_ready;
  item_t                    f_item;
  logic                     q_valid;
  logic                     q_ready;
  item_t                    q_item;
  logic signed [TEMP_W-1:0] temperature;

  assign pready = 1'b1;
  assign prdata = (paddr == REG_REF_MV) ? PDATA_W'(ref_mv) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      ref_mv <= REF_RESET;
    end else if (psel && penable && pwrite && pready && paddr == REG_REF_MV) begin
      ref_mv <= pwdata[REF_W-1:0];
    end
  end

  ttl_front #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .raw      (s_tdata[SAMPLE_BITS-1:0]),
    .ref_mv   (ref_mv),
    .out_valid(f_valid),
    .out_ready(f_ready),
    .out_item (f_item)
  );

  ttl_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .in_valid (f_valid),
    .in_ready (f_ready),
    .in_item  (f_item),
    .out_valid(q_valid),
    .out_ready(q_ready),
    .out_item (q_item)
  );

  ttl_back u_back (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (q_valid),
    .in_ready   (q_ready),
    .in_item    (q_item),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .temperature(temperature)
  );

  assign m_tdata = {{(OUT_TDATA_W - TEMP_W){1'b0}}, temperature};

endmodule

`default_nettype wire

// File: sim/tb_thermistor_table_linearizer.sv
`timescale 1ns / 100ps

module tb_thermistor_table_linearizer;
  import ttl_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_SAMPLES = 145;

  localparam int DIVIDER_MV [TABLE_POINTS] = '{
    3980, 3940, 3890, 3826, 3748, 3653, 3541, 3409, 3259, 3091,
    2908, 2712, 2508, 2300, 2093, 1890, 1696, 1513, 1343, 1188,
    1047, 921, 809, 710, 623, 546, 480, 421, 371
  };

  // With a 4096 mV reference one count is 4 mV: both ends of the sample range,
  // exactly the top point, just above it, the 0-degree crossing and the low end.
  localparam int PROBES_4096 [10] = '{0, 1023, 995, 996, 994, 885, 886, 592, 93, 92};
  // With a 1024 mV reference one count is 1 mV: around and at the last point.
  localparam int PROBES_1024 [7] = '{370, 371, 372, 421, 422, 546, 1023};

  class temp_scoreboard;
    logic [REF_W-1:0] ref_mv;
    logic signed [TEMP_W-1:0] pending[$];
    int errors;

    function new();
      ref_mv = REF_RESET;
      errors = 0;
    endfunction

    function logic signed [TEMP_W-1:0] predict_temp(input logic [9:0] raw);
      int unsigned mv;
      int unsigned hi;
      int unsigned lo;
      int unsigned num;
      int unsigned den;
      int unsigned q;
      int seg;
      int base;
      mv = (int'(raw) * int'(ref_mv) + 512) >> 10;
      if (mv < DIVIDER_MV[TABLE_POINTS-1]) return TEMP_LOW_MARK;
      if (mv > DIVIDER_MV[0]) return TEMP_HIGH_MARK;
      seg = TABLE_POINTS - 1;
      for (int j = TABLE_POINTS - 1; j >= 1; j--) begin
        if (DIVIDER_MV[j] < mv) seg = j;
      end
      hi = DIVIDER_MV[seg-1];
      lo = DIVIDER_MV[seg];
      den = hi - lo;
      num = TEMP_STEP * (hi - mv);
      base = -30 + TEMP_STEP * (seg - 1);
      // The fraction is truncated toward zero, so it rounds up below zero degrees.
      if (base >= 0) begin
        q = num / den;
      end else begin
        q = (num + den - 1) / den;
      end
      return TEMP_W'(base + int'(q));
    endfunction

    function void note_sample(input logic [9:0] raw);
      pending.push_back(predict_temp(raw));
    endfunction

    function void check_result(input logic signed [TEMP_W-1:0] temp);
      logic signed [TEMP_W-1:0] want;
      if (pending.size() == 0) begin
        $error("temperature: no result expected, got %0d", temp);
        errors++;
      end else begin
        want = pending.pop_front();
        if (temp !== want) begin
          $error("temperature: expected %0d, actual %0d", want, temp);
          errors++;
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [15:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  bit steady = 1'b0;
  int cycles = 0;
  temp_scoreboard sb;

  thermistor_table_linearizer dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata[TEMP_W-1:0]);
    m_tready <= steady || ($urandom_range(99) >= 28);
  end

  task automatic send_sample(input logic [9:0] raw);
    int gap;
    gap = 0;
    if (!steady && $urandom_range(99) < 28) gap = $urandom_range(1, 2);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= 16'(raw);
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_sample(raw);
  endtask

  task automatic drain;
    s_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  task automatic write_reference(input logic [REF_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= REG_REF_MV;
    pwdata <= PDATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.ref_mv = value;
  endtask

  // Most samples are aimed into the table so that every segment is exercised.
  function automatic logic [9:0] pick_sample(input logic [REF_W-1:0] ref_v);
    int unsigned target;
    int unsigned raw;
    if (ref_v == 0 || $urandom_range(99) < 30) return 10'($urandom_range(1023));
    target = $urandom_range(371, 3980);
    raw = (target * 1024 + ref_v / 2) / ref_v;
    if (raw > 1023) raw = $urandom_range(1023);
    return 10'(raw);
  endfunction

  initial begin : stimulus
    logic [REF_W-1:0] settings[$];
    sb = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_reference(REF_W'(4096));
    foreach (PROBES_4096[i]) send_sample(10'(PROBES_4096[i]));
    drain();
    write_reference(REF_W'(1024));
    foreach (PROBES_1024[i]) send_sample(10'(PROBES_1024[i]));

    settings = '{REF_W'(4096), REF_W'(1024), REF_W'(8192), REF_W'(0), REF_W'(16383),
                 REF_W'(2500), REF_W'($urandom_range(1024, 8192)),
                 REF_W'($urandom_range(1024, 8192))};
    foreach (settings[i]) begin
      drain();
      write_reference(settings[i]);
      steady = (i == 2);
      repeat (PHASE_SAMPLES) send_sample(pick_sample(settings[i]));
      steady = 1'b0;
    end

    drain();
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
